[src/lfu_pkg.sv]
`default_nettype none

package lfu_pkg;

  // Store geometry
  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 5;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = IDX_W;
  localparam int USED_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (USED_W > CFG_W) ? USED_W : CFG_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CFG_W-1:0]      CAP_RESET = CFG_W'(16);

  // Request opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_PLACE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    wr_value;
    logic                    evict;
    logic [IDX_W-1:0]        sel_idx;
    logic [IDX_W-1:0]        vic_idx;
    logic [RANK_W-1:0]       ref_rank;
    logic [DATA_W-1:0]       key;
    logic [DATA_W-1:0]       value;
  } cell_cmd_t;

  // Status a cell reports to the sequencer
  typedef struct packed {
    logic              valid;
    logic              match;
    logic [RANK_W-1:0] rank;
  } cell_stat_t;

  // Victim candidate passed down the chain
  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_W-1:0]     rank;
    logic [IDX_W-1:0]      idx;
  } cand_t;

endpackage

`default_nettype wire

[src/lfu_cache_policy.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_op, in_key, in_value
// out_      output     out_valid/out_ready  out_hit, out_read_value, out_evicted
// cfg_      input      cfg_we (no wait)     cfg_wdata (cap_in_use)
//
// Get hit or put hit: look, touch, done. Put into a free slot: look, apply,
// done. Get miss or put at zero capacity: look, done. A put that must evict
// searches first, the victim candidate walking the chain one cell per cycle.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// One transaction is in flight at a time; a finished result waits in the
// output register, and the sequencer holds in its done state while it is full.

module lfu_cache_policy (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic signed [lfu_pkg::DATA_W-1:0] in_key,
  input  logic signed [lfu_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic signed [lfu_pkg::DATA_W-1:0] out_read_value,
  output logic                             out_evicted,
  input  logic                             cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0]         cfg_wdata
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_TOUCH,
    S_SRCH,
    S_APPLY,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic                  req_op_r;
  logic [DATA_W-1:0]     req_key_r;
  logic [DATA_W-1:0]     req_val_r;
  logic [IDX_W-1:0]      sel_idx_r;
  logic [RANK_W-1:0]     ref_rank_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  evict_mode_r;
  logic [IDX_W-1:0]      cnt_r;
  logic [USED_W-1:0]     used_r;
  logic [CFG_W-1:0]      cap_r;
  logic                  res_hit_r;
  logic [DATA_W-1:0]     res_rd_r;
  logic                  res_ev_r;
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [DATA_W-1:0]     out_rd_r;
  logic                  out_ev_r;

  cell_cmd_t             cmd;
  cell_stat_t            stat_w  [CAPACITY];
  logic [DATA_W-1:0]     value_w [CAPACITY];
  cand_t                 cand_w  [CAPACITY+1];
  cand_t                 tail;

  logic [CAPACITY-1:0]   match_vec;
  logic [CAPACITY-1:0]   valid_vec;
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [DATA_W-1:0]     hit_val;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      limit;
  logic                  limit_zero;
  logic                  need_evict;
  logic                  do_evict;
  logic                  do_place;
  logic [IDX_W-1:0]      place_idx;
  logic                  srch_last;
  logic                  out_free;

  // Row of cells
  assign cand_w[0] = '0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .cmd      (cmd),
      .cand_in  (cand_w[g]),
      .cand_out (cand_w[g+1]),
      .stat     (stat_w[g]),
      .value    (value_w[g])
    );
  end
  assign tail = cand_w[CAPACITY];

  // Gather hit, hit rank/value and the lowest free slot
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    hit_val  = '0;
    free_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = stat_w[i].match;
      valid_vec[i] = stat_w[i].valid;
      if (stat_w[i].match) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | stat_w[i].rank;
        hit_val  = hit_val | value_w[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!stat_w[i].valid) free_idx = IDX_W'(i);
    end
  end

  assign any_hit    = |match_vec;
  assign free_found = ~&valid_vec;

  // Effective limit is min(cap_in_use, CAPACITY)
  assign cap_ext    = CMP_W'(cap_r);
  assign limit      = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
  assign limit_zero = (cap_r == '0);
  assign need_evict = (CMP_W'(used_r) >= limit) || !free_found;

  // Placement after an optional eviction
  assign do_evict  = evict_mode_r && tail.found;
  assign do_place  = do_evict || free_found_r;
  assign place_idx = (do_evict && !(free_found_r && (free_idx_r < tail.idx))) ?
                     tail.idx : free_idx_r;

  // Command to the cells
  always_comb begin
    cmd          = '0;
    cmd.kind     = CMD_NONE;
    cmd.key      = req_key_r;
    cmd.value    = req_val_r;
    cmd.wr_value = (req_op_r == OP_PUT);
    case (state_r)
      S_TOUCH: begin
        cmd.kind     = CMD_TOUCH;
        cmd.sel_idx  = sel_idx_r;
        cmd.ref_rank = ref_rank_r;
      end
      S_APPLY: begin
        if (do_place) cmd.kind = CMD_PLACE;
        cmd.sel_idx  = place_idx;
        cmd.evict    = do_evict;
        cmd.vic_idx  = tail.idx;
        cmd.ref_rank = tail.rank;
      end
      default: ;
    endcase
  end

  assign srch_last = (cnt_r == IDX_W'(CAPACITY - 1));
  assign out_free  = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK: begin
        if (req_op_r == OP_GET) begin
          state_nxt = any_hit ? S_TOUCH : S_DONE;
        end else if (limit_zero) begin
          state_nxt = S_DONE;
        end else if (any_hit) begin
          state_nxt = S_TOUCH;
        end else begin
          state_nxt = need_evict ? S_SRCH : S_APPLY;
        end
      end
      S_TOUCH: state_nxt = S_DONE;
      S_SRCH:  if (srch_last) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_rd_r    <= '0;
      out_ev_r    <= 1'b0;
      used_r      <= '0;
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      // Result register: load on the way out of done, clear once taken
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= res_hit_r;
        out_rd_r    <= res_rd_r;
        out_ev_r    <= res_ev_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOOK: cnt_r <= '0;
        S_SRCH: cnt_r <= cnt_r + 1'b1;
        S_APPLY: if (do_place && !do_evict) used_r <= used_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_op_r  <= in_op;
        req_key_r <= in_key;
        req_val_r <= in_value;
      end
      S_LOOK: begin
        sel_idx_r    <= hit_idx;
        ref_rank_r   <= hit_rank;
        free_found_r <= free_found;
        free_idx_r   <= free_idx;
        evict_mode_r <= need_evict;
        res_hit_r    <= any_hit && ((req_op_r == OP_GET) || !limit_zero);
        res_rd_r     <= (any_hit && (req_op_r == OP_GET)) ? hit_val : '1;
        res_ev_r     <= 1'b0;
      end
      S_APPLY: res_ev_r <= do_evict;
      default: ;
    endcase
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rd_r;
  assign out_evicted    = out_ev_r;

endmodule

`default_nettype wire

[src/lfu_cell.sv]
`default_nettype none

module lfu_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lfu_pkg::IDX_W-1:0] cell_idx,
  input  lfu_pkg::cell_cmd_t        cmd,
  input  lfu_pkg::cand_t            cand_in,
  output lfu_pkg::cand_t            cand_out,
  output lfu_pkg::cell_stat_t       stat,
  output logic [lfu_pkg::DATA_W-1:0] value
);
  import lfu_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [DATA_W-1:0]     key_r, key_nxt;
  logic [DATA_W-1:0]     value_r, value_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [RANK_W-1:0]     rank_r, rank_nxt;
  cand_t                 cand_r, cand_nxt;
  logic                  is_sel;
  logic                  is_vic;
  logic                  better;

  assign is_sel = (cell_idx == cmd.sel_idx);
  assign is_vic = cmd.evict && (cell_idx == cmd.vic_idx);

  // Entry update for touch and place commands
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    case (cmd.kind)
      CMD_TOUCH: begin
        if (is_sel) begin
          rank_nxt = '0;
          if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
          if (cmd.wr_value) value_nxt = cmd.value;
        end else if (valid_r && (rank_r < cmd.ref_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      CMD_PLACE: begin
        if (is_sel) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.key;
          value_nxt = cmd.value;
          count_nxt = COUNT_BITS'(1);
          rank_nxt  = '0;
        end else if (is_vic) begin
          valid_nxt = 1'b0;
        end else if (valid_r) begin
          // older than the victim: the removal and the insert cancel out
          if (!(cmd.evict && (rank_r > cmd.ref_rank))) rank_nxt = rank_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Victim search: lowest count wins, the older entry on equal counts
  assign better = valid_r &&
                  (!cand_in.found || (count_r < cand_in.count) ||
                   ((count_r == cand_in.count) && (rank_r > cand_in.rank)));

  always_comb begin
    cand_nxt = cand_in;
    if (better) begin
      cand_nxt.found = 1'b1;
      cand_nxt.count = count_r;
      cand_nxt.rank  = rank_r;
      cand_nxt.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    count_r <= count_nxt;
    rank_r  <= rank_nxt;
  end

  assign cand_out   = cand_r;
  assign stat.valid = valid_r;
  assign stat.match = valid_r && (key_r == cmd.key);
  assign stat.rank  = rank_r;
  assign value      = value_r;

endmodule

`default_nettype wire

[src/lfu_cache_policy_chk.sv]
`default_nettype none

module lfu_cache_policy_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [lfu_pkg::DATA_W-1:0]  out_read_value,
  input logic                        out_evicted
);
  import lfu_pkg::*;

  // One transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // An eviction only happens on a put miss
  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && (out_read_value == {DATA_W{1'b1}}))
    else $error("eviction reported with a hit or a read value");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_read_value) && $stable(out_evicted))
    else $error("result changed while stalled");

  // Reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind lfu_cache_policy lfu_cache_policy_chk u_lfu_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hit        (out_hit),
  .out_read_value (out_read_value),
  .out_evicted    (out_evicted)
);

`default_nettype wire
